// ===== rtl/uhpt_pkg.sv =====
// Shared types and constants of the uplink HARQ process tracker.
`timescale 1ns / 1ps

package uhpt_pkg;

  localparam int NUM_PROCESSES = 16;
  localparam int ADDR_W        = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;

  localparam logic [3:0] ROUND_LIMIT_RESET = 4'd4;
  localparam logic [3:0] ROUND_MAX         = 4'd15;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_GRANT  = 1'b1;

  typedef enum logic [1:0] {
    ST_INACTIVE   = 2'd0,
    ST_SCHEDULED  = 2'd1,
    ST_AWAIT_RETX = 2'd2
  } proc_state_t;

  typedef struct packed {
    logic       opcode;
    logic [3:0] process_id;
    logic       crc_failed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  new_state;
    logic        new_toggle;
    logic [3:0]  new_round;
    logic        released;
    logic        gave_up;
    logic        bad_report;
    logic [31:0] error_total;
  } out_item_t;

  typedef struct packed {
    proc_state_t state;
    logic        toggle;
    logic [3:0]  round;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    entry_t entry;
    logic   released;
    logic   gave_up;
    logic   bad_report;
    logic   write;
  } upd_t;

endpackage

// ===== rtl/uhpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module uhpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/uhpt_update.sv =====
// Per-item entry update: grant, CRC pass/fail, give-up and bad report decisions.
`timescale 1ns / 1ps

module uhpt_update (
  input  uhpt_pkg::in_item_t item,
  input  uhpt_pkg::entry_t   entry,
  input  logic [3:0]         round_limit,
  input  logic               in_range,
  output uhpt_pkg::upd_t     upd
);

  logic [3:0]       limit;
  logic [3:0]       round_inc;
  uhpt_pkg::entry_t step;

  always_comb begin
    limit     = (round_limit == 4'd0) ? 4'd1 : round_limit;
    round_inc = (entry.round == uhpt_pkg::ROUND_MAX) ? entry.round : entry.round + 4'd1;
    step      = entry;

    upd.entry      = entry;
    upd.released   = 1'b0;
    upd.gave_up    = 1'b0;
    upd.bad_report = 1'b0;
    upd.write      = 1'b0;

    if (!in_range) begin
      upd.entry      = '{state: uhpt_pkg::ST_INACTIVE, toggle: 1'b0, round: 4'd0};
      upd.bad_report = (item.opcode == uhpt_pkg::OP_REPORT);
    end else if (item.opcode == uhpt_pkg::OP_GRANT) begin
      upd.entry.state = uhpt_pkg::ST_SCHEDULED;
      upd.write       = 1'b1;
    end else if (entry.state != uhpt_pkg::ST_SCHEDULED) begin
      upd.bad_report = 1'b1;
    end else begin
      if (!item.crc_failed) begin
        step.toggle  = ~entry.toggle;
        step.round   = 4'd0;
        step.state   = uhpt_pkg::ST_INACTIVE;
        upd.released = 1'b1;
      end else begin
        step.round = round_inc;
        step.state = uhpt_pkg::ST_AWAIT_RETX;
      end
      // out of rounds: free the process and flip the toggle
      if (!(step.round < limit)) begin
        step.toggle  = ~step.toggle;
        step.state   = uhpt_pkg::ST_INACTIVE;
        step.round   = 4'd0;
        upd.released = 1'b1;
        upd.gave_up  = 1'b1;
      end
      upd.entry = step;
      upd.write = 1'b1;
    end
  end

endmodule

// ===== rtl/ul_harq_process_tracker_core.sv =====
// Top level of the uplink HARQ process tracker: handshakes, table RAM and error total.
`timescale 1ns / 1ps

// Uplink HARQ process tracker. Each item is either a grant (opcode 1), which marks
// a process scheduled, or a CRC report (opcode 0), which passes or fails a
// scheduled process; a report on a process that is not scheduled is flagged as a
// bad report and changes nothing. Every item yields exactly one result item with
// the process entry after the step, the released / gave_up / bad_report flags and
// the saturating total of given-up processes. Throughput is one item per clock
// while the output is not stalled. The table RAM read is registered with the item;
// update, write-back and output register follow. A write-back that lands on the
// entry the next item is reading is forwarded, so back-to-back items on the same
// process see fresh state. The table holds state, toggle and round per process in
// one RAM; a valid bit per entry, cleared by reset, makes never-written entries
// read as inactive with zero toggle and round, so no clearing pass is needed after
// reset. round_limit is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, not enforced by the block; a value of 0 acts as 1.
module ul_harq_process_tracker_core (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  uhpt_pkg::in_item_t  in_data,

  output logic                out_valid,
  input  logic                out_ready,
  output uhpt_pkg::out_item_t out_data,

  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata
);

  localparam int AW = uhpt_pkg::ADDR_W;

  // config
  logic [3:0] round_limit_r;

  // stage 1: RAM data arrives, entry is updated
  logic                s1_valid_r;
  uhpt_pkg::in_item_t  s1_item_r;
  logic [AW-1:0]       s1_addr;
  logic                s1_in_range;
  logic                s1_go;

  // forwarding of the write-back that coincided with this item's read
  logic                fwd_hit_r;
  uhpt_pkg::entry_t    fwd_entry_r;

  // per-entry valid bits, cleared by reset
  logic [uhpt_pkg::NUM_PROCESSES-1:0] valid_r;

  // output register
  logic                out_valid_r;
  uhpt_pkg::out_item_t out_data_r;

  logic [31:0]         err_cnt_r;
  logic [31:0]         err_cnt_nxt;

  logic                in_accept;
  logic [AW-1:0]       rd_addr;
  logic [uhpt_pkg::ENTRY_W-1:0] ram_rdata;
  logic                wr_en;
  uhpt_pkg::entry_t    cur_entry;
  uhpt_pkg::upd_t      upd;

  // handshakes
  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_accept = in_valid && in_ready;

  assign rd_addr     = AW'(in_data.process_id);
  assign s1_addr     = AW'(s1_item_r.process_id);
  assign s1_in_range = (32'(s1_item_r.process_id) < 32'(uhpt_pkg::NUM_PROCESSES));

  assign wr_en = s1_go && upd.write;

  uhpt_ram #(
    .WIDTH (uhpt_pkg::ENTRY_W),
    .DEPTH (uhpt_pkg::NUM_PROCESSES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (upd.entry),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // current entry: forwarded write-back, else RAM if ever written, else reset value
  always_comb begin
    if (fwd_hit_r) begin
      cur_entry = fwd_entry_r;
    end else if (s1_in_range && valid_r[s1_addr]) begin
      cur_entry = uhpt_pkg::entry_t'(ram_rdata);
    end else begin
      cur_entry = '{state: uhpt_pkg::ST_INACTIVE, toggle: 1'b0, round: 4'd0};
    end
  end

  uhpt_update u_update (
    .item        (s1_item_r),
    .entry       (cur_entry),
    .round_limit (round_limit_r),
    .in_range    (s1_in_range),
    .upd         (upd)
  );

  // saturating give-up total
  always_comb begin
    err_cnt_nxt = err_cnt_r;
    if (upd.gave_up && (err_cnt_r != 32'hFFFF_FFFF)) begin
      err_cnt_nxt = err_cnt_r + 32'd1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_limit_r <= uhpt_pkg::ROUND_LIMIT_RESET;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      fwd_hit_r     <= 1'b0;
      valid_r       <= '0;
      err_cnt_r     <= 32'd0;
    end else begin
      if (cfg_we) begin
        round_limit_r <= cfg_wdata;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= wr_en && (s1_addr == rd_addr);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
        err_cnt_r   <= err_cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[s1_addr] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r   <= in_data;
      fwd_entry_r <= upd.entry;
    end
    if (s1_go) begin
      out_data_r.new_state   <= upd.entry.state;
      out_data_r.new_toggle  <= upd.entry.toggle;
      out_data_r.new_round   <= upd.entry.round;
      out_data_r.released    <= upd.released;
      out_data_r.gave_up     <= upd.gave_up;
      out_data_r.bad_report  <= upd.bad_report;
      out_data_r.error_total <= err_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== bench/ul_harq_process_tracker_core_tb.sv =====
// Self-checking testbench for the uplink HARQ process tracker core.
`timescale 1ns / 1ps

module ul_harq_process_tracker_core_tb;
  import uhpt_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic       cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  ul_harq_process_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predicted process table: a private copy of state, toggle and round per
  // process, the give-up total and the round limit in force.
  // ---------------------------------------------------------------------------
  proc_state_t tbl_state  [NUM_PROCESSES];
  logic        tbl_toggle [NUM_PROCESSES];
  logic [3:0]  tbl_round  [NUM_PROCESSES];
  logic [31:0] giveup_total;
  logic [3:0]  limit_reg;

  out_item_t outcome_q[$];    // expected result items, oldest first

  int in_idle_pct  = 0;       // chance per cycle that the sender holds off
  int out_idle_pct = 0;       // chance per cycle that the receiver stalls
  int items_sent      = 0;
  int results_checked = 0;
  int giveups_seen    = 0;
  int error_count     = 0;
  logic [3:0] last_pid = 4'd0;

  // Applies one item to the predicted table and returns the result it yields.
  function automatic out_item_t harq_step(in_item_t it);
    out_item_t   res;
    int unsigned pid;
    logic [3:0]  eff_limit;
    res = '0;
    pid = 32'(it.process_id);
    eff_limit = (limit_reg == 4'd0) ? 4'd1 : limit_reg;   // zero limit acts as one
    if (pid >= NUM_PROCESSES) begin
      // Index beyond the table: nothing moves, only a report is flagged.
      res.bad_report = (it.opcode == OP_REPORT);
    end else if (it.opcode == OP_GRANT) begin
      // Grant schedules whatever the prior state; toggle and round stay.
      tbl_state[pid] = ST_SCHEDULED;
    end else if (tbl_state[pid] != ST_SCHEDULED) begin
      res.bad_report = 1'b1;
    end else begin
      if (!it.crc_failed) begin
        tbl_toggle[pid] = ~tbl_toggle[pid];
        tbl_round[pid]  = 4'd0;
        tbl_state[pid]  = ST_INACTIVE;
        res.released    = 1'b1;
      end else begin
        if (tbl_round[pid] != ROUND_MAX) tbl_round[pid] = tbl_round[pid] + 4'd1;
        tbl_state[pid] = ST_AWAIT_RETX;
      end
      // Out of rounds: free the process and count it, saturating.
      if (tbl_round[pid] >= eff_limit) begin
        tbl_toggle[pid] = ~tbl_toggle[pid];
        tbl_round[pid]  = 4'd0;
        tbl_state[pid]  = ST_INACTIVE;
        if (giveup_total != 32'hFFFF_FFFF) giveup_total = giveup_total + 32'd1;
        res.released = 1'b1;
        res.gave_up  = 1'b1;
      end
    end
    if (pid < NUM_PROCESSES) begin
      res.new_state  = tbl_state[pid];
      res.new_toggle = tbl_toggle[pid];
      res.new_round  = tbl_round[pid];
    end
    res.error_total = giveup_total;
    return res;
  endfunction

  function automatic in_item_t harq_item(logic op, logic [3:0] pid, logic failed);
    in_item_t it;
    it.opcode     = op;
    it.process_id = pid;
    it.crc_failed = failed;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a falling edge, returns at a falling edge with valid
  // still high, so back-to-back items never lower and raise it in one step.
  // The expectation is pushed at the accepting edge, in acceptance order.
  // ---------------------------------------------------------------------------
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_q.push_back(harq_step(it));
    items_sent++;
    last_pid = it.process_id;
    @(negedge clk);
  endtask

  // Holds the sender off until every expected result is in, then lets the
  // pipeline settle.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_round_limit(logic [3:0] value);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    limit_reg  = value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls at random, decided at each falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic check_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
      error_count++;
    end
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t ns: result item with nothing expected, got %h", $time, out_data);
        error_count++;
      end else begin
        exp_res = outcome_q.pop_front();
        check_field("new_state",   32'(exp_res.new_state),   32'(out_data.new_state));
        check_field("new_toggle",  32'(exp_res.new_toggle),  32'(out_data.new_toggle));
        check_field("new_round",   32'(exp_res.new_round),   32'(out_data.new_round));
        check_field("released",    32'(exp_res.released),    32'(out_data.released));
        check_field("gave_up",     32'(exp_res.gave_up),     32'(out_data.gave_up));
        check_field("bad_report",  32'(exp_res.bad_report),  32'(out_data.bad_report));
        check_field("error_total", exp_res.error_total, out_data.error_total);
        results_checked++;
        if (exp_res.gave_up) giveups_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed: default limit of four. Reports on idle processes, a re-grant,
  // a pass, a report while awaiting retransmission, and a full run of fails
  // up to a give-up. Grants carry crc_failed high at times; it must not matter.
  // ---------------------------------------------------------------------------
  task automatic test_reports_and_grants();
    send_item(harq_item(OP_REPORT, 4'd0,  1'b0));   // inactive: bad report
    send_item(harq_item(OP_REPORT, 4'd15, 1'b1));   // inactive: bad report
    send_item(harq_item(OP_GRANT,  4'd0,  1'b1));
    send_item(harq_item(OP_GRANT,  4'd0,  1'b0));   // grant on scheduled
    send_item(harq_item(OP_REPORT, 4'd0,  1'b0));   // pass: toggle flips
    send_item(harq_item(OP_GRANT,  4'd10, 1'b0));
    send_item(harq_item(OP_REPORT, 4'd10, 1'b1));   // round 1
    send_item(harq_item(OP_REPORT, 4'd10, 1'b1));   // awaiting retx: bad report
    for (int r = 0; r < 3; r++) begin
      send_item(harq_item(OP_GRANT,  4'd10, 1'b1)); // retransmission grant
      send_item(harq_item(OP_REPORT, 4'd10, 1'b1)); // last one gives up
    end
  endtask

  // Directed: limit of zero (acts as one), top limit, a limit lowered to a
  // round already reached, and a limit of one with a pass.
  task automatic test_round_limit_extremes();
    write_round_limit(4'd0);
    send_item(harq_item(OP_GRANT,  4'd5, 1'b0));
    send_item(harq_item(OP_REPORT, 4'd5, 1'b1));    // first fail gives up
    write_round_limit(4'd15);
    for (int r = 0; r < 2; r++) begin
      send_item(harq_item(OP_GRANT,  4'd3, 1'b0));
      send_item(harq_item(OP_REPORT, 4'd3, 1'b1));
    end
    write_round_limit(4'd2);
    send_item(harq_item(OP_GRANT,  4'd3, 1'b0));
    send_item(harq_item(OP_REPORT, 4'd3, 1'b1));    // round 3 over limit 2
    write_round_limit(4'd1);
    send_item(harq_item(OP_GRANT,  4'd6, 1'b0));
    send_item(harq_item(OP_REPORT, 4'd6, 1'b0));    // pass is no give-up
  endtask

  // Mostly well-formed traffic: grant a process that is not scheduled, report
  // on a scheduled one, often on the same process as the item before so that
  // back-to-back updates of one entry are common. The rest is arbitrary noise.
  task automatic run_harq_traffic(int count);
    in_item_t it;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 40) it.process_id = last_pid;
      else it.process_id = 4'($urandom_range(0, NUM_PROCESSES - 1));
      it.crc_failed = ($urandom_range(0, 99) < 55);
      if ($urandom_range(0, 99) < 15) it.opcode = 1'($urandom_range(0, 1));
      else it.opcode = (tbl_state[it.process_id] == ST_SCHEDULED) ? OP_REPORT : OP_GRANT;
      send_item(it);
      // Once per batch the sender waits for the pipeline to empty.
      if (k == count / 2) wait_results_drained();
    end
  endtask

  task automatic test_random_traffic();
    in_idle_pct  = 7;
    out_idle_pct = 77;
    write_round_limit(4'd15);
    run_harq_traffic(260);
    in_idle_pct  = 77;
    out_idle_pct = 7;
    write_round_limit(4'($urandom_range(0, 3)));
    run_harq_traffic(260);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_round_limit(ROUND_LIMIT_RESET);
    run_harq_traffic(260);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    for (int p = 0; p < NUM_PROCESSES; p++) begin
      tbl_state[p]  = ST_INACTIVE;
      tbl_toggle[p] = 1'b0;
      tbl_round[p]  = 4'd0;
    end
    giveup_total = 32'd0;
    limit_reg    = ROUND_LIMIT_RESET;
    in_idle_pct  = 7;
    out_idle_pct = 77;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reports_and_grants();
    test_round_limit_extremes();
    test_random_traffic();
    wait_results_drained();

    $display("Covered: %0d items, %0d results checked, %0d give-ups seen.",
             items_sent, results_checked, giveups_seen);
    $display("Round limits 0, 1, 2, 4, 15 and random; three idle/stall mixes.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", outcome_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/uhpt_pkg.sv
rtl/uhpt_ram.sv
rtl/uhpt_update.sv
rtl/ul_harq_process_tracker_core.sv
bench/ul_harq_process_tracker_core_tb.sv
